// ----- rtl/core/ads_pkg.sv -----
// Shared types and constants for the apogee deployment sequencer.
// No dependencies; the interfaces and the top level use it by scoped names.
package ads_pkg;

  // Field widths
  localparam int AccelW  = 15;
  localparam int AltW    = 24;
  localparam int PotW    = 10;
  localparam int ThrW    = 14;
  localparam int MarginW = 16;
  localparam int ScaleW  = 14;
  localparam int FireW   = 14;
  localparam int CountW  = 14;
  localparam int PhaseW  = 3;
  localparam int ProdW   = PotW + ScaleW;

  // Config port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Full-scale pot code, also the delay divisor
  localparam logic [PotW-1:0] POT_MAX = 10'd1023;

  typedef enum logic [PhaseW-1:0] {
    PH_PAD    = 3'd0,
    PH_FLIGHT = 3'd1,
    PH_DELAY  = 3'd2,
    PH_FIRING = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_LAUNCH_THRESHOLD = 2'd0,
    REG_APOGEE_MARGIN    = 2'd1,
    REG_DELAY_FULL_SCALE = 2'd2,
    REG_FIRE_TIME        = 2'd3
  } reg_idx_t;

  // Register reset values
  localparam logic [ThrW-1:0]    LAUNCH_THRESHOLD_RST = 14'd200;
  localparam logic [MarginW-1:0] APOGEE_MARGIN_RST    = 16'd75;
  localparam logic [ScaleW-1:0]  DELAY_FULL_SCALE_RST = 14'd10000;
  localparam logic [FireW-1:0]   FIRE_TIME_RST        = 14'd5000;

  // Accepted item as held in the input stage
  typedef struct packed {
    logic                   tick;
    logic signed [AccelW-1:0] vert_accel;
    logic signed [AltW-1:0]   altitude;
    logic [ProdW-1:0]         delay_prod;  // (1023 - pot) * full scale
  } stage_item_t;

endpackage

// ----- rtl/core/ads_in_if.sv -----
// Input channel: sensor sample or millisecond tick, valid/ready handshake.
// Depends on ads_pkg for field widths.
interface ads_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic signed [ads_pkg::AccelW-1:0] vert_accel;
  logic signed [ads_pkg::AltW-1:0]   altitude;
  logic [ads_pkg::PotW-1:0]          pot_reading;

  modport source (output valid, cmd, vert_accel, altitude, pot_reading, input ready);
  modport sink   (input valid, cmd, vert_accel, altitude, pot_reading, output ready);
endinterface

// ----- rtl/core/ads_out_if.sv -----
// Result channel: phase, pyro state, peak altitude and time left.
// Depends on ads_pkg for field widths.
interface ads_out_if;
  logic                            valid;
  logic                            ready;
  logic [ads_pkg::PhaseW-1:0]      phase;
  logic                            pyro_fire;
  logic signed [ads_pkg::AltW-1:0] peak_altitude;
  logic [ads_pkg::CountW-1:0]      time_left;

  modport source (output valid, phase, pyro_fire, peak_altitude, time_left, input ready);
  modport sink   (input valid, phase, pyro_fire, peak_altitude, time_left, output ready);
endinterface

// ----- rtl/core/apogee_deploy_sequencer.sv -----
// Apogee deployment sequencer: launch detect, peak tracking, delay and pyro timing.
// Items pass through the input stage, then the result register. Throughput:
// one item per cycle unless the output stalls; the sequencer state updates once
// per item as it moves from the input stage to the result register.
// Reset (rst, synchronous): phase pad, peak 0, countdown 0, registers to defaults.
// Depends on ads_pkg, ads_in_if and ads_out_if.
module apogee_deploy_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  ads_in_if.sink                      in_ch,
  ads_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ads_pkg::AddrW-1:0]   paddr,
  input  logic [ads_pkg::DataW-1:0]   pwdata,
  output logic [ads_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int QW   = ads_pkg::ProdW + 1 - 10;  // quotient estimate width
  localparam int CmpW = ads_pkg::AltW + 2;        // altitude + margin compare width

  // Config registers
  logic [ads_pkg::ThrW-1:0]    launch_threshold;
  logic [ads_pkg::MarginW-1:0] apogee_margin;
  logic [ads_pkg::ScaleW-1:0]  delay_full_scale;
  logic [ads_pkg::FireW-1:0]   fire_time;
  ads_pkg::reg_idx_t           reg_sel;
  logic                        cfg_wr;

  // Pipeline and sequencer state
  logic                          s1_valid;
  ads_pkg::stage_item_t          s1_item;
  ads_pkg::stage_item_t          s1_item_next;
  logic                          s1_adv;
  logic                          out_valid;
  ads_pkg::phase_t               phase;
  ads_pkg::phase_t               phase_next;
  logic signed [ads_pkg::AltW-1:0] peak;
  logic signed [ads_pkg::AltW-1:0] peak_next;
  logic [ads_pkg::CountW-1:0]    countdown;
  logic [ads_pkg::CountW-1:0]    countdown_next;

  // Datapath
  logic [ads_pkg::PotW-1:0]      pot_inv;
  logic [ads_pkg::ProdW:0]       div_sum;
  logic [QW-1:0]                 q_est;
  logic [ads_pkg::ProdW:0]       div_rem;
  logic [ads_pkg::CountW-1:0]    delay_ms;
  logic                          zero_delay;
  logic                          launch;
  logic signed [CmpW-1:0]        peak_ext;
  logic signed [CmpW-1:0]        alt_limit;
  logic                          deploy;
  logic [ads_pkg::CountW-1:0]    count_dec;

  // APB: always ready, write on access phase
  assign pready  = 1'b1;
  assign reg_sel = ads_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      ads_pkg::REG_LAUNCH_THRESHOLD: prdata = ads_pkg::DataW'(launch_threshold);
      ads_pkg::REG_APOGEE_MARGIN:    prdata = ads_pkg::DataW'(apogee_margin);
      ads_pkg::REG_DELAY_FULL_SCALE: prdata = ads_pkg::DataW'(delay_full_scale);
      ads_pkg::REG_FIRE_TIME:        prdata = ads_pkg::DataW'(fire_time);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_threshold <= ads_pkg::LAUNCH_THRESHOLD_RST;
      apogee_margin    <= ads_pkg::APOGEE_MARGIN_RST;
      delay_full_scale <= ads_pkg::DELAY_FULL_SCALE_RST;
      fire_time        <= ads_pkg::FIRE_TIME_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        ads_pkg::REG_LAUNCH_THRESHOLD: launch_threshold <= pwdata[ads_pkg::ThrW-1:0];
        ads_pkg::REG_APOGEE_MARGIN:    apogee_margin    <= pwdata[ads_pkg::MarginW-1:0];
        ads_pkg::REG_DELAY_FULL_SCALE: delay_full_scale <= pwdata[ads_pkg::ScaleW-1:0];
        ads_pkg::REG_FIRE_TIME:        fire_time        <= pwdata[ads_pkg::FireW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input stage moves on when the result register is free or drains
  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  // Input stage: capture item, form the delay product
  assign pot_inv = ads_pkg::POT_MAX - in_ch.pot_reading;

  always_comb begin
    s1_item_next.tick       = in_ch.cmd;
    s1_item_next.vert_accel = in_ch.vert_accel;
    s1_item_next.altitude   = in_ch.altitude;
    s1_item_next.delay_prod = ads_pkg::ProdW'(pot_inv) * ads_pkg::ProdW'(delay_full_scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_item <= s1_item_next;
    end
  end

  // Divide product by 1023: x/1024 * (1 + 2^-10 + 2^-20) underestimates by at
  // most one, so one remainder check corrects it
  assign div_sum = {1'b0, s1_item.delay_prod}
                 + (ads_pkg::ProdW + 1)'(s1_item.delay_prod >> 10)
                 + (ads_pkg::ProdW + 1)'(s1_item.delay_prod >> 20);
  assign q_est   = div_sum[ads_pkg::ProdW:10];
  assign div_rem = {1'b0, s1_item.delay_prod} - {q_est, 10'b0}
                 + (ads_pkg::ProdW + 1)'(q_est);
  assign delay_ms = ads_pkg::CountW'(q_est)
                  + ads_pkg::CountW'(div_rem >= (ads_pkg::ProdW + 1)'(ads_pkg::POT_MAX));
  assign zero_delay = s1_item.delay_prod < ads_pkg::ProdW'(ads_pkg::POT_MAX);

  // Launch and apogee compares
  assign launch    = $signed({s1_item.vert_accel[ads_pkg::AccelW-1], s1_item.vert_accel})
                   > $signed({2'b00, launch_threshold});
  assign peak_ext  = CmpW'(peak);
  assign alt_limit = CmpW'(s1_item.altitude)
                   + $signed({{(CmpW - ads_pkg::MarginW){1'b0}}, apogee_margin});
  assign deploy    = peak_ext > alt_limit;
  assign count_dec = (countdown != '0) ? countdown - 1'b1 : countdown;

  // Sequencer next state
  always_comb begin
    phase_next     = phase;
    peak_next      = peak;
    countdown_next = countdown;
    if (!s1_item.tick) begin
      if ((phase == ads_pkg::PH_PAD && launch) || phase == ads_pkg::PH_FLIGHT) begin
        phase_next = ads_pkg::PH_FLIGHT;
        if (s1_item.altitude > peak) begin
          peak_next = s1_item.altitude;
        end
        if (deploy) begin
          if (!zero_delay) begin
            phase_next     = ads_pkg::PH_DELAY;
            countdown_next = delay_ms;
          end else if (fire_time == '0) begin
            phase_next     = ads_pkg::PH_DONE;
            countdown_next = '0;
          end else begin
            phase_next     = ads_pkg::PH_FIRING;
            countdown_next = fire_time;
          end
        end
      end
    end else begin
      case (phase)
        ads_pkg::PH_DELAY: begin
          countdown_next = count_dec;
          if (count_dec == '0) begin
            if (fire_time == '0) begin
              phase_next = ads_pkg::PH_DONE;
            end else begin
              phase_next     = ads_pkg::PH_FIRING;
              countdown_next = fire_time;
            end
          end
        end
        ads_pkg::PH_FIRING: begin
          countdown_next = count_dec;
          if (count_dec == '0) begin
            phase_next = ads_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ads_pkg::PH_PAD;
      peak      <= '0;
      countdown <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase     <= phase_next;
        peak      <= peak_next;
        countdown <= countdown_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_ch.phase         <= phase_next;
      out_ch.pyro_fire     <= (phase_next == ads_pkg::PH_FIRING);
      out_ch.peak_altitude <= peak_next;
      out_ch.time_left     <= (phase_next == ads_pkg::PH_DELAY
                               || phase_next == ads_pkg::PH_FIRING) ? countdown_next : '0;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
